// ===== design/lpht_pkg.sv =====
// Shared types, codes and widths of the linear-probing hash table.
package lpht_pkg;

    localparam int SLOTS_DEF      = 1024;
    localparam int KEY_BITS_DEF   = 32;
    localparam int VALUE_BITS_DEF = 32;

    localparam int FIELD_W   = 32;
    localparam int CFG_W     = 11;
    localparam int CMD_W     = 2;
    localparam int STATUS_W  = 3;
    localparam int HASH_W    = 32;
    localparam int DIV_CNT_W = $clog2(HASH_W);
    localparam int S_DATA_W  = 3 * FIELD_W;
    localparam int M_DATA_W  = 56;

    localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_GET   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    typedef enum logic [STATUS_W-1:0] {
        ST_FOUND     = 3'd0,
        ST_INSERTED  = 3'd1,
        ST_UPDATED   = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_FULL      = 3'd4,
        ST_CLEARED   = 3'd5
    } status_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic    load;
        logic    clr_step;
        logic    div_step;
        logic    issue;
        logic    advance;
        logic    write_entry;
        logic    insert;
        logic    capture;
        logic    set_status;
        status_t status;
        logic    emit;
    } lpht_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic [CMD_W-1:0] op;
        logic             key_reserved;
        logic             div_last;
        logic             clr_last;
        logic             slot_empty;
        logic             slot_match;
        logic             probes_done;
        logic             out_busy;
    } lpht_stat_t;

endpackage

// ===== design/lpht_ctrl.sv =====
// Controller state machine of the linear-probing hash table.
module lpht_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  lpht_pkg::lpht_stat_t stat,
    output lpht_pkg::lpht_cmd_t  cmd
);
    import lpht_pkg::*;

    typedef enum logic [2:0] {
        S_INIT_CLR,
        S_IDLE,
        S_DECODE,
        S_DIV,
        S_ISSUE,
        S_CHECK,
        S_CLR,
        S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   ready_reg, ready_next;

    assign s_tready = ready_reg;

    // Decode next state and datapath commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.status = ST_NOT_FOUND;
        case (state_reg)
            S_INIT_CLR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (s_tvalid && ready_reg)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                cmd.set_status = 1'b1;
                if (stat.op == CMD_CLEAR)
                begin
                    cmd.status = ST_CLEARED;
                    state_next = S_CLR;
                end
                else if (stat.op == CMD_PUT && stat.key_reserved)
                begin
                    cmd.status = ST_CLEARED;
                    state_next = S_DONE;
                end
                else if (stat.op == CMD_PUT)
                begin
                    cmd.status = ST_FULL;
                    state_next = S_DIV;
                end
                else if (stat.op == CMD_GET)
                begin
                    state_next = S_DIV;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                    state_next = S_ISSUE;
            end
            S_ISSUE:
            begin
                cmd.issue  = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (stat.slot_empty)
                begin
                    cmd.set_status = 1'b1;
                    if (stat.op == CMD_PUT)
                    begin
                        cmd.write_entry = 1'b1;
                        cmd.insert      = 1'b1;
                        cmd.status      = ST_INSERTED;
                    end
                    state_next = S_DONE;
                end
                else if (stat.slot_match)
                begin
                    cmd.set_status = 1'b1;
                    if (stat.op == CMD_PUT)
                    begin
                        cmd.write_entry = 1'b1;
                        cmd.status      = ST_UPDATED;
                    end
                    else
                    begin
                        cmd.capture = 1'b1;
                        cmd.status  = ST_FOUND;
                    end
                    state_next = S_DONE;
                end
                else if (stat.probes_done)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.advance = 1'b1;
                    state_next  = S_ISSUE;
                end
            end
            S_CLR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!stat.out_busy)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        ready_next = (state_next == S_IDLE);
    end

    // Hold state and registered ready
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT_CLR;
            ready_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= ready_next;
        end
    end

endmodule

// ===== design/lpht_datapath.sv =====
// Datapath of the linear-probing hash table: slot memories, modulo unit, output register.
module lpht_datapath #(
    parameter int SLOTS      = lpht_pkg::SLOTS_DEF,
    parameter int KEY_BITS   = lpht_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS = lpht_pkg::VALUE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [lpht_pkg::S_DATA_W-1:0] s_tdata,
    input  logic [lpht_pkg::CMD_W-1:0]    s_tuser,
    input  logic                          s_tlast,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [lpht_pkg::CFG_W-1:0]    cfg_data,
    input  lpht_pkg::lpht_cmd_t           cmd,
    output lpht_pkg::lpht_stat_t          stat,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [lpht_pkg::M_DATA_W-1:0] m_tdata,
    output logic [lpht_pkg::STATUS_W-1:0] m_tuser,
    output logic                          m_tlast
);
    import lpht_pkg::*;

    localparam int AW    = $clog2(SLOTS);
    localparam int CMPW  = ((AW > CFG_W) ? AW : CFG_W) + 1;
    localparam int REM_W = CFG_W + 1;

    // Slot memories
    logic [KEY_BITS-1:0]   key_mem [SLOTS];
    logic [VALUE_BITS-1:0] val_mem [SLOTS];
    logic [KEY_BITS-1:0]   key_q_reg;
    logic [VALUE_BITS-1:0] val_q_reg;

    // Request latches
    logic [CMD_W-1:0]      op_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [HASH_W-1:0]     hash_reg;
    logic [VALUE_BITS-1:0] value_reg;
    logic                  last_reg;

    // Control and working registers
    logic [CFG_W-1:0]      slots_cfg_reg;
    logic [CFG_W-1:0]      used_reg;
    logic [CFG_W-1:0]      probes_reg;
    logic [AW-1:0]         pos_reg;
    logic [AW-1:0]         clr_idx_reg;
    logic [CFG_W-1:0]      rem_reg;
    logic [DIV_CNT_W-1:0]  div_cnt_reg;
    status_t               status_reg;
    logic [VALUE_BITS-1:0] rd_reg;

    // Output register
    logic                  m_valid_reg;
    logic [STATUS_W-1:0]   m_status_reg;
    logic [FIELD_W-1:0]    m_rd_reg;
    logic [CFG_W-1:0]      m_occ_reg;
    logic [CFG_W-1:0]      m_probes_reg;
    logic                  m_last_reg;

    logic [CMPW-1:0]       cfg_ext;
    logic [CFG_W-1:0]      n_active;
    logic [REM_W-1:0]      rem_shift;
    logic [REM_W-1:0]      rem_sub;
    logic [CFG_W-1:0]      rem_next;
    logic [CMPW-1:0]       pos_inc;
    logic                  pos_wrap;

    assign cfg_ready = 1'b1;

    // Clamp the slot count to one through SLOTS
    assign cfg_ext  = CMPW'(slots_cfg_reg);
    assign n_active = (slots_cfg_reg == '0) ? CFG_W'(1) :
                      (cfg_ext > CMPW'(SLOTS)) ? CFG_W'(SLOTS) : slots_cfg_reg;

    // One restoring step of hash modulo slot count
    assign rem_shift = {rem_reg, hash_reg[HASH_W-1]};
    assign rem_sub   = rem_shift - REM_W'(n_active);
    assign rem_next  = (rem_shift >= REM_W'(n_active)) ? rem_sub[CFG_W-1:0]
                                                       : rem_shift[CFG_W-1:0];

    // Forward probe with wrap
    assign pos_inc  = CMPW'(pos_reg) + CMPW'(1);
    assign pos_wrap = (pos_inc >= CMPW'(n_active));

    // Status back to the controller
    assign stat.op           = op_reg;
    assign stat.key_reserved = (key_reg == '1);
    assign stat.div_last     = (div_cnt_reg == DIV_CNT_W'(HASH_W - 1));
    assign stat.clr_last     = (clr_idx_reg == AW'(SLOTS - 1));
    assign stat.slot_empty   = (key_q_reg == '1);
    assign stat.slot_match   = (key_q_reg == key_reg);
    assign stat.probes_done  = (probes_reg == n_active);
    assign stat.out_busy     = m_valid_reg && !m_tready;

    // Write and read the slot memories
    always_ff @(posedge clk)
    begin
        if (cmd.clr_step)
            key_mem[clr_idx_reg] <= '1;
        else if (cmd.write_entry)
            key_mem[pos_reg] <= key_reg;
        if (cmd.write_entry)
            val_mem[pos_reg] <= value_reg;
        if (cmd.issue)
        begin
            key_q_reg <= key_mem[pos_reg];
            val_q_reg <= val_mem[pos_reg];
        end
    end

    // Latch the request and run the working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg      <= s_tuser;
            key_reg     <= KEY_BITS'(s_tdata[FIELD_W-1:0]);
            hash_reg    <= s_tdata[2*FIELD_W-1:FIELD_W];
            value_reg   <= VALUE_BITS'(s_tdata[3*FIELD_W-1:2*FIELD_W]);
            last_reg    <= s_tlast;
            probes_reg  <= '0;
            rem_reg     <= '0;
            div_cnt_reg <= '0;
            rd_reg      <= '0;
        end
        if (cmd.div_step)
        begin
            rem_reg     <= rem_next;
            hash_reg    <= {hash_reg[HASH_W-2:0], 1'b0};
            div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
            if (stat.div_last)
                pos_reg <= AW'(rem_next);
        end
        if (cmd.issue)
            probes_reg <= probes_reg + CFG_W'(1);
        if (cmd.advance)
            pos_reg <= pos_wrap ? '0 : pos_inc[AW-1:0];
        if (cmd.set_status)
            status_reg <= cmd.status;
        if (cmd.capture)
            rd_reg <= val_q_reg;
    end

    // Hold configuration, fill count, clear index and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slots_cfg_reg <= CFG_W'(SLOTS_DEF);
            used_reg      <= '0;
            clr_idx_reg   <= '0;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                slots_cfg_reg <= cfg_data;
            if (cmd.load && s_tuser == CMD_CLEAR)
                used_reg <= '0;
            else if (cmd.insert)
                used_reg <= used_reg + CFG_W'(1);
            if (cmd.clr_step)
                clr_idx_reg <= stat.clr_last ? '0 : clr_idx_reg + AW'(1);
            if (cmd.emit)
                m_valid_reg <= 1'b1;
            else if (m_tready)
                m_valid_reg <= 1'b0;
        end
    end

    // Load the result into the output register
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            m_status_reg <= status_reg;
            m_rd_reg     <= FIELD_W'(rd_reg);
            m_occ_reg    <= used_reg;
            m_probes_reg <= probes_reg;
            m_last_reg   <= last_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {{(M_DATA_W - FIELD_W - 2*CFG_W){1'b0}}, m_probes_reg, m_occ_reg, m_rd_reg};

endmodule

// ===== design/linear_probe_hash_table_unit.sv =====
// Top level of the linear-probing hash table: controller plus datapath.
//
// Requests enter on the s_ group: tuser carries the command (put, get,
// clear), tdata the key, hash and value, tlast a batch marker that comes
// back on the result. Every request yields exactly one result on the m_
// group: tuser the status, tdata read value, occupancy and probe count.
// cfg_valid/cfg_data write the slot count used for the modulo and wrap.
// For a put or get, the bit-serial modulo unit first reduces the hash
// to a slot; each probe then does a registered read of the key memory,
// and the result goes out once the search ends. A clear sweeps every
// memory row, one row per cycle; reserved-key puts and unknown commands
// go from decode straight to the result. After reset the key memory is
// swept to empty, with s_tready low. One request is in work at a time; a
// result waiting in the output register does not block the next request,
// but a second result waits until the receiver takes it.
module linear_probe_hash_table_unit #(
    parameter int SLOTS      = lpht_pkg::SLOTS_DEF,
    parameter int KEY_BITS   = lpht_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS = lpht_pkg::VALUE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // key [31:0], hash [63:32], value [95:64]
    input  logic [lpht_pkg::S_DATA_W-1:0] s_tdata,
    // cmd [1:0]
    input  logic [lpht_pkg::CMD_W-1:0]    s_tuser,
    input  logic                          s_tlast,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [lpht_pkg::CFG_W-1:0]    cfg_data,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // read_value [31:0], occupancy [42:32], probe_count [53:43], zero [55:54]
    output logic [lpht_pkg::M_DATA_W-1:0] m_tdata,
    // status [2:0]
    output logic [lpht_pkg::STATUS_W-1:0] m_tuser,
    output logic                          m_tlast
);
    import lpht_pkg::*;

    lpht_cmd_t  cmd;
    lpht_stat_t stat;

    lpht_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    lpht_datapath #(
        .SLOTS      (SLOTS),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

// ===== verif/linear_probe_hash_table_unit_tb.sv =====
// Testbench for the linear-probing hash table: directed table plus random requests, scoreboarded.
module linear_probe_hash_table_unit_tb;
    import lpht_pkg::*;

    localparam int TBL_SLOTS = SLOTS_DEF;
    localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;
    localparam logic [31:0] EMPTY_KEY = 32'hFFFF_FFFF;
    localparam int STALL_LIMIT = 20000;
    localparam int SETTLE_CYCLES = 40;

    typedef struct packed {
        status_t     status;
        logic [31:0] read_value;
        logic [10:0] occupancy;
        logic [10:0] probe_count;
        logic        batch_end;
    } lookup_result_t;

    typedef struct {
        bit             set_size;
        logic [10:0]    size;
        logic [1:0]     cmd;
        logic [31:0]    key;
        logic [31:0]    hash;
        logic [31:0]    value;
        logic           last;
        bit             typed;
        lookup_result_t want;
    } dir_row_t;

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic [CMD_W-1:0]    s_tuser;
    logic                s_tlast;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [CFG_W-1:0]    cfg_data;
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0] m_tuser;
    logic                m_tlast;

    // Shadow copy of the table
    logic [31:0] shadow_keys [TBL_SLOTS];
    logic [31:0] shadow_vals [TBL_SLOTS];
    logic [10:0] shadow_count;
    logic [10:0] shadow_size;

    lookup_result_t pending_results[$];
    int             error_count;
    bit             idle_on;
    dir_row_t       dir_rows [19];
    int             phase_sizes [11];

    linear_probe_hash_table_unit DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // Compute the result of one request and update the shadow table
    function automatic lookup_result_t lookup_step(input logic [1:0] cmd,
        input logic [31:0] key, input logic [31:0] hash, input logic [31:0] value,
        input logic last);
        lookup_result_t r;
        int n;
        int pos;
        int probes;
        bit done;
        r.status = ST_NOT_FOUND;
        r.read_value = '0;
        probes = 0;
        done = 1'b0;
        if (cmd == CMD_CLEAR) begin
            foreach (shadow_keys[i]) shadow_keys[i] = EMPTY_KEY;
            shadow_count = '0;
            r.status = ST_CLEARED;
        end else if (cmd == CMD_PUT && key == EMPTY_KEY) begin
            r.status = ST_CLEARED;
        end else if (cmd == CMD_PUT || cmd == CMD_GET) begin
            n = (shadow_size == 0) ? 1 : ((shadow_size > TBL_SLOTS) ? TBL_SLOTS : shadow_size);
            pos = int'(hash % 32'(n));
            r.status = (cmd == CMD_PUT) ? ST_FULL : ST_NOT_FOUND;
            while (probes < n && !done) begin
                probes++;
                if (shadow_keys[pos] == EMPTY_KEY) begin
                    if (cmd == CMD_PUT) begin
                        shadow_keys[pos] = key;
                        shadow_vals[pos] = value;
                        shadow_count = shadow_count + 11'd1;
                        r.status = ST_INSERTED;
                    end else begin
                        r.status = ST_NOT_FOUND;
                    end
                    done = 1'b1;
                end else if (shadow_keys[pos] == key) begin
                    if (cmd == CMD_PUT) begin
                        shadow_vals[pos] = value;
                        r.status = ST_UPDATED;
                    end else begin
                        r.read_value = shadow_vals[pos];
                        r.status = ST_FOUND;
                    end
                    done = 1'b1;
                end else begin
                    pos = (pos + 1 >= n) ? 0 : pos + 1;
                end
            end
        end
        r.occupancy = shadow_count;
        r.probe_count = 11'(probes);
        r.batch_end = last;
        return r;
    endfunction

    // Drive one request and record its expected result on acceptance
    task automatic send_request(input logic [1:0] cmd, input logic [31:0] key,
        input logic [31:0] hash, input logic [31:0] value, input logic last,
        input bit typed, input lookup_result_t want);
        int gap;
        lookup_result_t r;
        gap = idle_on ? $urandom_range(0, 14) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {value, hash, key};
        s_tlast <= last;
        do @(posedge clk); while (!s_tready);
        r = lookup_step(cmd, key, hash, value, last);
        pending_results.push_back(typed ? want : r);
    endtask

    // Write the slot count once every result is back
    task automatic write_size(input logic [10:0] size);
        s_tvalid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= size;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        shadow_size = size;
    endtask

    // Build one random request for a table of n slots
    task automatic send_random(input int n);
        int pick;
        logic [1:0] cmd;
        logic [31:0] key;
        logic [31:0] hash;
        pick = $urandom_range(0, 99);
        cmd = (pick < 50) ? CMD_PUT : (pick < 94) ? CMD_GET : (pick < 97) ? CMD_CLEAR : CMD_NONE;
        pick = $urandom_range(0, 99);
        key = (pick < 85) ? 32'($urandom_range(0, 2 * n + 3)) :
              (pick < 95) ? $urandom() : EMPTY_KEY;
        hash = ($urandom_range(0, 9) == 0) ? $urandom() : key * 32'h9E37_79B1;
        send_request(cmd, key, hash, $urandom(), 1'($urandom()), 1'b0, '0);
    endtask

    function automatic void report_field(input string name, input logic [31:0] want,
        input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            error_count++;
        end
    endfunction

    // Receive results with random stalls and check them in order
    initial
    begin
        lookup_result_t want;
        int stall;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = idle_on ? $urandom_range(0, 14) : 0;
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result, status %0d", $time, m_tuser);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                report_field("status", 32'(want.status), 32'(m_tuser));
                report_field("read_value", want.read_value, m_tdata[31:0]);
                report_field("occupancy", 32'(want.occupancy), 32'(m_tdata[42:32]));
                report_field("probe_count", 32'(want.probe_count), 32'(m_tdata[53:43]));
                report_field("batch_end", 32'(want.batch_end), 32'(m_tlast));
            end
        end
    end

    // Abort when no handshake happens for too long
    initial
    begin
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= STALL_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // Main sequence
    initial
    begin
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        s_tlast = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        rst_n = 1'b0;
        error_count = 0;
        idle_on = 1'b1;
        foreach (shadow_keys[i]) shadow_keys[i] = EMPTY_KEY;
        foreach (shadow_vals[i]) shadow_vals[i] = '0;
        shadow_count = '0;
        shadow_size = 11'd1024;

        // Directed rows: miss, reserved key, extremes, collisions, clear, full table
        dir_rows = '{
            '{0, 0, CMD_GET,   32'd5, 32'd0, 32'd0, 0, 1, '{ST_NOT_FOUND, 0, 0, 1, 0}},
            '{0, 0, CMD_PUT,   EMPTY_KEY, 32'd7, 32'd9, 0, 1, '{ST_CLEARED, 0, 0, 0, 0}},
            '{0, 0, CMD_PUT,   32'd0, '1, '1, 1, 1, '{ST_INSERTED, 0, 1, 1, 1}},
            '{0, 0, CMD_GET,   32'd0, '1, 32'd0, 0, 0, '0},
            '{0, 0, CMD_PUT,   32'd0, '1, 32'd0, 1, 0, '0},
            '{0, 0, CMD_PUT,   32'd1, '1, 32'h1234_5678, 0, 0, '0},
            '{0, 0, CMD_GET,   EMPTY_KEY, 32'h3FF, 32'd0, 0, 0, '0},
            '{0, 0, CMD_GET,   32'd1, '1, '1, 1, 0, '0},
            '{0, 0, CMD_NONE,  32'd1, '1, '1, 0, 0, '0},
            '{0, 0, CMD_CLEAR, '1, '1, '1, 1, 1, '{ST_CLEARED, 0, 0, 0, 1}},
            '{0, 0, CMD_GET,   32'd0, '1, 32'd0, 0, 1, '{ST_NOT_FOUND, 0, 0, 1, 0}},
            '{1, 11'd2, CMD_PUT, 32'd0, 32'd0, 32'd0, 0, 0, '0},
            '{0, 0, CMD_PUT,   32'd10, 32'd0, 32'hA5A5_A5A5, 0, 0, '0},
            '{0, 0, CMD_PUT,   32'd11, 32'd0, 32'h5A5A_5A5A, 0, 0, '0},
            '{0, 0, CMD_PUT,   32'd12, 32'd1, 32'd3, 0, 0, '0},
            '{0, 0, CMD_GET,   32'd13, 32'd1, 32'd0, 1, 0, '0},
            '{0, 0, CMD_GET,   EMPTY_KEY, 32'd0, 32'd0, 0, 0, '0},
            '{0, 0, CMD_PUT,   32'd11, 32'd1, 32'd4, 0, 0, '0},
            '{0, 0, CMD_GET,   32'd11, 32'd0, 32'd0, 1, 0, '0}
        };
        phase_sizes = '{0, 8, 2047, 3, 1, 16, 1024, 5, 2, 32, 64};

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Walk the directed table
        foreach (dir_rows[i])
        begin
            if (dir_rows[i].set_size)
                write_size(dir_rows[i].size);
            else
                send_request(dir_rows[i].cmd, dir_rows[i].key, dir_rows[i].hash,
                    dir_rows[i].value, dir_rows[i].last, dir_rows[i].typed, dir_rows[i].want);
        end

        // Random phases at several table sizes, no clear between them
        foreach (phase_sizes[p])
        begin
            int n;
            int count;
            n = (phase_sizes[p] == 0) ? 1 :
                (phase_sizes[p] > TBL_SLOTS) ? TBL_SLOTS : phase_sizes[p];
            count = (n >= TBL_SLOTS) ? 40 : 150;
            write_size(11'(phase_sizes[p]));
            for (int i = 0; i < count; i++)
            begin
                if (i % 32 == 0)
                    idle_on = ($urandom_range(0, 3) != 0);
                send_random(n);
            end
        end

        // Drain and settle
        s_tvalid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
